>>> sv/cxpc_pkg.sv
// Package for the chained XOR packet cipher.
// Holds field widths, region offsets and the control struct shared by
// the tracker and the chaining datapath. No dependencies.
package cxpc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 10;
	localparam int unsigned SEED_W = 32;
	localparam int unsigned POS_W  = 10;
	localparam int unsigned LANE_W = 2;

	localparam int unsigned MAX_PACKET_BYTES_DEF = 512;

	// A zero first byte means the longer, two-byte header.
	localparam logic [BYTE_W-1:0] HDR_MARK_BYTE  = 8'h00;
	localparam logic [1:0]        START_LONG_HDR = 2'd2;
	localparam logic [1:0]        START_SHORT_HDR = 2'd1;
	localparam logic [LEN_W:0]    OVERHEAD_LONG  = 11'd4;
	localparam logic [LEN_W:0]    OVERHEAD_SHORT = 11'd3;
	localparam logic [LANE_W-1:0] LAST_LANE      = 2'd3;

	localparam logic FUNC_ENCRYPT = 1'b0;
	localparam logic FUNC_DECRYPT = 1'b1;

	// Decode of the current word against the packet context.
	typedef struct packed {
		logic              open;      // word starts a packet
		logic              dir;       // effective direction
		logic              in_block;  // inside the whole-block part of the region
		logic              in_tail;   // inside the leftover bytes
		logic [LANE_W-1:0] lane;      // byte lane within the 4-byte block
		logic              eop;
		logic              too_long;
	} cxpc_ctl_t;

endpackage

>>> sv/cxpc_if.sv
// Stream interfaces of the chained XOR packet cipher: packet input,
// result output and the session seed write channel.
// Depends on cxpc_pkg for field widths.
interface cxpc_in_if;
	logic                          valid;
	logic                          ready;
	logic                          func;
	logic [cxpc_pkg::BYTE_W-1:0]   data_byte;
	logic                          start_of_packet;
	logic [cxpc_pkg::LEN_W-1:0]    packet_length;

	modport source (output valid, output func, output data_byte,
		output start_of_packet, output packet_length, input ready);
	modport sink (input valid, input func, input data_byte,
		input start_of_packet, input packet_length, output ready);
endinterface

interface cxpc_out_if;
	logic                          valid;
	logic                          ready;
	logic [cxpc_pkg::BYTE_W-1:0]   out_byte;
	logic                          end_of_packet;
	logic                          too_long;

	modport source (output valid, output out_byte, output end_of_packet,
		output too_long, input ready);
	modport sink (input valid, input out_byte, input end_of_packet,
		input too_long, output ready);
endinterface

interface cxpc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cxpc_pkg::SEED_W-1:0]   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/cxpc_tracker.sv
// Packet context tracker: byte position, region bounds, length, direction.
// Decodes each incoming word into a cxpc_pkg::cxpc_ctl_t for the datapath.
// Depends on cxpc_pkg.
module cxpc_tracker #(
	parameter int unsigned MAX_PACKET_BYTES = cxpc_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          func,
	input  logic [cxpc_pkg::BYTE_W-1:0]   data_byte,
	input  logic                          start_of_packet,
	input  logic [cxpc_pkg::LEN_W-1:0]    packet_length,
	output cxpc_pkg::cxpc_ctl_t           ctl
);

	localparam logic [31:0] MAX_LEN = 32'(MAX_PACKET_BYTES);

	logic [cxpc_pkg::POS_W-1:0] pos_q;
	logic [1:0]                 start_q;
	logic [cxpc_pkg::POS_W-1:0] bend_q;
	logic [cxpc_pkg::POS_W-1:0] rend_q;
	logic [cxpc_pkg::LEN_W-1:0] len_q;
	logic                       dir_q;

	logic [cxpc_pkg::POS_W-1:0] pos;
	logic [1:0]                 start;
	logic [cxpc_pkg::POS_W-1:0] bend;
	logic [cxpc_pkg::POS_W-1:0] rend;
	logic [cxpc_pkg::LEN_W-1:0] len;
	logic                       dir;

	logic [1:0]                 new_start;
	logic [cxpc_pkg::LEN_W:0]   span;
	logic                       new_long;
	logic                       new_empty;
	logic [cxpc_pkg::POS_W-1:0] new_bend;
	logic [cxpc_pkg::POS_W-1:0] new_rend;
	logic [cxpc_pkg::LEN_W:0]   pos_inc;

	always_comb begin
		if (data_byte == cxpc_pkg::HDR_MARK_BYTE) begin
			new_start = cxpc_pkg::START_LONG_HDR;
			span = {1'b0, packet_length} - cxpc_pkg::OVERHEAD_LONG;
		end else begin
			new_start = cxpc_pkg::START_SHORT_HDR;
			span = {1'b0, packet_length} - cxpc_pkg::OVERHEAD_SHORT;
		end
		new_long = {22'd0, packet_length} > MAX_LEN;
		// The span is negative when its top bit is set, empty when zero.
		new_empty = span[cxpc_pkg::LEN_W] || (span == '0);
		if (new_long || new_empty) begin
			new_bend = '0;
			new_rend = '0;
		end else begin
			new_bend = {8'd0, new_start} + {span[cxpc_pkg::LEN_W-1:2], 2'b00};
			new_rend = {8'd0, new_start} + span[cxpc_pkg::LEN_W-1:0];
		end

		if (start_of_packet) begin
			pos   = '0;
			start = new_start;
			bend  = new_bend;
			rend  = new_rend;
			len   = packet_length;
			dir   = func;
		end else begin
			pos   = pos_q;
			start = start_q;
			bend  = bend_q;
			rend  = rend_q;
			len   = len_q;
			dir   = dir_q;
		end

		pos_inc = {1'b0, pos} + 11'd1;

		ctl.open     = start_of_packet;
		ctl.dir      = dir;
		ctl.in_block = (pos >= {8'd0, start}) && (pos < bend);
		ctl.in_tail  = (pos >= bend) && (pos < rend);
		ctl.lane     = pos[1:0] - start;
		ctl.eop      = (len != '0) && (pos_inc == {1'b0, len});
		ctl.too_long = {22'd0, len} > MAX_LEN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			bend_q  <= '0;
			rend_q  <= '0;
			len_q   <= '0;
			dir_q   <= 1'b0;
		end else if (accept) begin
			start_q <= start;
			bend_q  <= bend;
			rend_q  <= rend;
			len_q   <= len;
			dir_q   <= dir;
			// Bytes past the end keep counting but the position saturates.
			if (pos != '1) begin
				pos_q <= pos_inc[cxpc_pkg::POS_W-1:0];
			end else begin
				pos_q <= pos;
			end
		end
	end

endmodule

>>> sv/cxpc_chain.sv
// Seed chaining datapath and result register of the packet cipher.
// XORs each whole-block byte with its lane of the running seed and each tail byte
// with its low byte, and collects ciphertext. Depends on cxpc_pkg and the decode from cxpc_tracker.
module cxpc_chain (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          res_ready,
	input  logic [cxpc_pkg::SEED_W-1:0]   session_seed,
	input  logic [cxpc_pkg::BYTE_W-1:0]   data_byte,
	input  cxpc_pkg::cxpc_ctl_t           ctl,
	output logic                          res_valid,
	output logic [cxpc_pkg::BYTE_W-1:0]   res_byte,
	output logic                          res_eop,
	output logic                          res_too_long
);

	logic [cxpc_pkg::SEED_W-1:0] seed_q;
	logic [cxpc_pkg::SEED_W-1:0] collect_q;
	logic                        valid_q;
	logic [cxpc_pkg::BYTE_W-1:0] byte_q;
	logic                        eop_q;
	logic                        too_long_q;

	logic [cxpc_pkg::SEED_W-1:0] seed;
	logic [cxpc_pkg::SEED_W-1:0] collect;
	logic [cxpc_pkg::SEED_W-1:0] collect_upd;
	logic [cxpc_pkg::BYTE_W-1:0] lane_key;
	logic [cxpc_pkg::BYTE_W-1:0] result;
	logic [cxpc_pkg::BYTE_W-1:0] cipher;

	always_comb begin
		seed    = ctl.open ? session_seed : seed_q;
		collect = ctl.open ? '0 : collect_q;
		lane_key = seed[{ctl.lane, 3'b000} +: cxpc_pkg::BYTE_W];
		if (ctl.in_block) begin
			result = data_byte ^ lane_key;
		end else if (ctl.in_tail) begin
			result = data_byte ^ seed[cxpc_pkg::BYTE_W-1:0];
		end else begin
			result = data_byte;
		end
		// The chain always carries the ciphertext side of the block.
		cipher = (ctl.dir == cxpc_pkg::FUNC_DECRYPT) ? data_byte : result;
		collect_upd = collect;
		collect_upd[{ctl.lane, 3'b000} +: cxpc_pkg::BYTE_W] = cipher;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= '0;
			collect_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				if (ctl.in_block) begin
					collect_q <= collect_upd;
					seed_q    <= (ctl.lane == cxpc_pkg::LAST_LANE) ? collect_upd : seed;
				end else begin
					collect_q <= collect;
					seed_q    <= seed;
				end
			end
			valid_q <= accept || (valid_q && !res_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q     <= result;
			eop_q      <= ctl.eop;
			too_long_q <= ctl.too_long;
		end
	end

	assign res_valid    = valid_q;
	assign res_byte     = byte_q;
	assign res_eop      = eop_q;
	assign res_too_long = too_long_q;

endmodule

>>> sv/chained_xor_packet_cipher.sv
// Chained XOR packet cipher, top level.
// An accepted byte's result is in the output register in the next cycle.
// Throughput: one byte per cycle; the byte decode and lane XOR sit between the
// context registers and the output register, and input ready only drops while
// a result waits to be taken.
// Reset clears the packet context, the seeds and the output valid at once.
module chained_xor_packet_cipher #(
	parameter int unsigned MAX_PACKET_BYTES = cxpc_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cxpc_in_if.sink     pkt,
	cxpc_out_if.source  res,
	cxpc_cfg_if.sink    seed_cfg
);

	logic                          accept;
	logic [cxpc_pkg::SEED_W-1:0]   session_seed_q;
	cxpc_pkg::cxpc_ctl_t           ctl;

	assign pkt.ready      = !res.valid || res.ready;
	assign accept         = pkt.valid && pkt.ready;
	assign seed_cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_seed_q <= '0;
		end else if (seed_cfg.valid && seed_cfg.ready) begin
			session_seed_q <= seed_cfg.data;
		end
	end

	cxpc_tracker #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.func            (pkt.func),
		.data_byte       (pkt.data_byte),
		.start_of_packet (pkt.start_of_packet),
		.packet_length   (pkt.packet_length),
		.ctl             (ctl)
	);

	cxpc_chain u_chain (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.res_ready    (res.ready),
		.session_seed (session_seed_q),
		.data_byte    (pkt.data_byte),
		.ctl          (ctl),
		.res_valid    (res.valid),
		.res_byte     (res.out_byte),
		.res_eop      (res.end_of_packet),
		.res_too_long (res.too_long)
	);

endmodule

>>> sv/cxpc_checker.sv
// Port-level checker for the chained XOR packet cipher, with its bind.
// Watches the packet and result channels only. Depends on cxpc_pkg and
// the interfaces in cxpc_if.
module cxpc_checker #(
	parameter int unsigned MAX_PACKET_BYTES = cxpc_pkg::MAX_PACKET_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	cxpc_in_if.sink     pkt,
	cxpc_out_if.source  res
);

	localparam logic [31:0] MAX_LEN = 32'(MAX_PACKET_BYTES);

	logic acc;
	assign acc = pkt.valid && pkt.ready;

	// A result that is not taken stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid)
		else $error("result word dropped while stalled");

	// An empty output register never blocks the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> pkt.ready)
		else $error("input stalled with no result pending");

	// Every accepted word shows up as a result in the next cycle.
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> res.valid)
		else $error("accepted word produced no result");

	// The first word of a packet is header and passes unchanged.
	a_header_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pkt.start_of_packet |=> res.out_byte == $past(pkt.data_byte))
		else $error("header word was altered");

	// An oversize length is flagged from the first word on.
	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		acc && pkt.start_of_packet |=>
		res.too_long == ({22'd0, $past(pkt.packet_length)} > MAX_LEN))
		else $error("too_long flag wrong on first word");

endmodule

bind chained_xor_packet_cipher cxpc_checker #(
	.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
) u_cxpc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pkt    (pkt),
	.res    (res)
);
